// ===== sv/efts_pkg.sv =====
// ----------------------------------------------------------------------------
// efts_pkg
// shared types and constants of the event queue with per-type push counters
// ----------------------------------------------------------------------------
package efts_pkg;

  localparam int unsigned ACT_W   = 2;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PEND_W  = 7;
  localparam int unsigned CNT_W   = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_QUERY,
    OP_TOTAL
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // queue entry, stored as one memory word
  typedef struct packed {
    logic [WORD_W-1:0] etime;
    logic [WORD_W-1:0] aux;
    logic [ID_W-1:0]   etype;
  } entry_t;

  // input tdata, last field in the low bits
  typedef struct packed {
    logic [WORD_W-1:0] now_us;
    logic [WORD_W-1:0] aux_data;
    logic [ID_W-1:0]   event_id;
  } in_data_t;

  // output tdata, last field in the low bits
  typedef struct packed {
    logic              overflow;
    logic [CNT_W-1:0]  stat_count;
    logic [PEND_W-1:0] pending;
    logic [WORD_W-1:0] out_time;
    logic [WORD_W-1:0] out_aux;
    logic [ID_W-1:0]   out_event_id;
  } out_data_t;

  localparam int unsigned IN_DATA_W  = $bits(in_data_t);
  localparam int unsigned OUT_DATA_W = $bits(out_data_t);

endpackage

// ===== sv/efts_queue_mem.sv =====
// ----------------------------------------------------------------------------
// efts_queue_mem
// event storage: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module efts_queue_mem
  import efts_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/efts_count_mem.sv =====
// ----------------------------------------------------------------------------
// efts_count_mem
// per-type push counters: memory with registered read and per-entry valid
// bits so that every counter reads zero after reset
// ----------------------------------------------------------------------------
module efts_count_mem
  import efts_pkg::*;
#(
  parameter int unsigned KINDS = 8,
  parameter int unsigned AW    = (KINDS > 1) ? $clog2(KINDS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [CNT_W-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [CNT_W-1:0] wdata_i
);

  logic [CNT_W-1:0] mem_q [KINDS];
  logic [KINDS-1:0] vld_q;
  logic [CNT_W-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== sv/event_fifo_with_type_stats_core.sv =====
// ----------------------------------------------------------------------------
// event_fifo_with_type_stats_core
// event queue with per-type push counters and a sticky overflow freeze
// ----------------------------------------------------------------------------
// result is written to the output register in the following execute state
// no new transaction is taken until the execute state ends: the memory read
//   comes first, then the counter write-back in the execute cycle
// a result still waiting at the output holds the execute cycle and so the input
// reset: indices, occupancy, counters (via valid bits) and freeze flag clear at
//   once; queue contents stay undefined, there is no clearing pass
module event_fifo_with_type_stats_core
  import efts_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned EVENT_KINDS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // event_id, aux_data, now_us
  input  logic [ACT_W-1:0]      s_axis_tuser,  // action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_event_id, out_aux, out_time, pending, stat_count, overflow
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned QAW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned KAW   = (EVENT_KINDS > 1) ? $clog2(EVENT_KINDS) : 1;
  localparam logic [QAW-1:0]   LAST_SLOT = QAW'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(QUEUE_DEPTH);
  localparam logic [ID_W:0]    KINDS_LIM = (ID_W + 1)'(EVENT_KINDS);

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [OCC_W-1:0]  pend_q;
  logic [KAW-1:0]    kidx_q;
  logic [QAW-1:0]    ridx_q, widx_q;
  logic [OCC_W-1:0]  occ_q;
  logic [CNT_W-1:0]  total_q;
  logic              frozen_q, frozen_d;
  logic              out_valid_q;
  out_data_t         out_q, res;

  in_data_t          in_d;
  logic              accept, exec_done;
  logic              kind_ok, kind_nz;
  logic [KAW-1:0]    kidx;

  entry_t            q_wdata, q_rdata;
  logic              q_we, q_re;
  logic              c_re, c_we;
  logic [CNT_W-1:0]  c_rdata;

  assign in_d    = in_data_t'(s_axis_tdata);
  assign accept  = s_axis_tvalid & s_axis_tready;
  assign kind_ok = {1'b0, in_d.event_id} < KINDS_LIM;
  assign kind_nz = in_d.event_id != '0;
  assign kidx    = KAW'(in_d.event_id);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    exec_done     = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EXEC: exec_done = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // decode of an accepted transaction
  always_comb begin
    op_d     = OP_NONE;
    frozen_d = frozen_q;
    q_we     = 1'b0;
    q_re     = 1'b0;
    c_re     = 1'b0;
    if (accept && !frozen_q) begin
      case (s_axis_tuser)
        ACT_PUSH: begin
          if (kind_ok && kind_nz) begin
            if (occ_q == FULL_OCC) begin
              frozen_d = 1'b1;
            end else begin
              op_d = OP_PUSH;
              q_we = 1'b1;
              c_re = 1'b1;
            end
          end
        end
        ACT_POP: begin
          if (occ_q != '0) begin
            op_d = OP_POP;
            q_re = 1'b1;
          end
        end
        ACT_QUERY: begin
          if (!kind_nz) begin
            op_d = OP_TOTAL;
          end else if (kind_ok) begin
            op_d = OP_QUERY;
            c_re = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign q_wdata = '{etime: in_d.now_us, aux: in_d.aux_data, etype: in_d.event_id};

  efts_queue_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_mem (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (widx_q),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (ridx_q),
    .rdata_o (q_rdata)
  );

  assign c_we = exec_done && (op_q == OP_PUSH);

  efts_count_mem #(
    .KINDS (EVENT_KINDS)
  ) u_count_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (c_re),
    .raddr_i (kidx),
    .rdata_o (c_rdata),
    .we_i    (c_we),
    .waddr_i (kidx_q),
    .wdata_i (c_rdata + 1'b1)
  );

  // result of the executing transaction
  always_comb begin
    res          = '0;
    res.overflow = frozen_q;
    case (op_q)
      OP_POP: begin
        res.out_event_id = q_rdata.etype;
        res.out_aux      = q_rdata.aux;
        res.out_time     = q_rdata.etime;
        res.pending      = PEND_W'(pend_q);
      end
      OP_QUERY: res.stat_count = c_rdata;
      OP_TOTAL: res.stat_count = total_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NONE;
      ridx_q      <= '0;
      widx_q      <= '0;
      occ_q       <= '0;
      total_q     <= '0;
      frozen_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      frozen_q <= frozen_d;
      if (accept) begin
        op_q <= op_d;
      end
      if (q_we) begin
        widx_q  <= (widx_q == LAST_SLOT) ? '0 : widx_q + 1'b1;
        occ_q   <= occ_q + 1'b1;
        total_q <= total_q + 1'b1;
      end
      if (q_re) begin
        ridx_q <= (ridx_q == LAST_SLOT) ? '0 : ridx_q + 1'b1;
        occ_q  <= occ_q - 1'b1;
      end
      if (exec_done) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= occ_q;
      kidx_q <= kidx;
    end
    if (exec_done) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FULL_OCC)
    else $error("occupancy above queue depth");

  a_frozen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frozen_q |=> frozen_q)
    else $error("freeze flag cleared without reset");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC) && !s_axis_tready)
    else $error("transaction not followed by execute cycle");

  a_frozen_no_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frozen_q) |=> (op_q == OP_NONE))
    else $error("operation issued while frozen");

endmodule
